// ----- hdl/hat_tile_vertex_placer_unit_defines.svh -----
// Assertion helpers shared by the placer modules.
`ifndef HAT_TILE_VERTEX_PLACER_UNIT_DEFINES_SVH
`define HAT_TILE_VERTEX_PLACER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HTVP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define HTVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/htvp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package htvp_pkg;

	localparam int TILE_VERTS  = 14;
	localparam int TURN_STEPS  = 12;
	localparam int IDX_BITS    = 4;
	localparam int DIR_BITS    = 4;
	localparam int PFX_BITS    = 8;
	localparam int Q48         = 48;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(TILE_VERTS - 1);

	// Exact vertex coordinate: value = (a + b*sqrt3) / 2
	typedef logic signed [PFX_BITS-1:0] pfx_t;

	typedef struct packed {
		pfx_t ax;
		pfx_t bx;
		pfx_t ay;
		pfx_t by;
	} pfx_vec_t;

	// One tile handed from the chain builder to the emitter
	typedef struct packed {
		pfx_vec_t [TILE_VERTS-1:0] pts;
		logic                      refl;
		logic [IDX_BITS-1:0]       piv;
	} tile_geom_t;

	// (edge angle + 1) mod 12 for the forward and the mirrored walk
	localparam logic [3:0] E1_FWD [TILE_VERTS] =
		'{4'd11, 4'd1, 4'd4, 4'd6, 4'd3, 4'd5, 4'd8, 4'd6, 4'd9, 4'd7, 4'd10, 4'd0, 4'd0, 4'd2};
	localparam logic [3:0] E1_REF [TILE_VERTS] =
		'{4'd1, 4'd11, 4'd8, 4'd6, 4'd9, 4'd7, 4'd4, 4'd6, 4'd3, 4'd5, 4'd2, 4'd0, 4'd0, 4'd10};
	localparam logic EDGE_LONG [TILE_VERTS] =
		'{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

	// 2*cos(k*30deg) = COS_INT[k] + COS_RT3[k]*sqrt3
	localparam logic signed [2:0] COS_INT [TURN_STEPS] =
		'{3'sd2, 3'sd0, 3'sd1, 3'sd0, -3'sd1, 3'sd0, -3'sd2, 3'sd0, -3'sd1, 3'sd0, 3'sd1, 3'sd0};
	localparam logic signed [1:0] COS_RT3 [TURN_STEPS] =
		'{2'sd0, 2'sd1, 2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd1};

	// floor(sqrt3 * 2^48), digit by digit; elaboration only
	function automatic logic [63:0] sqrt3_q48();
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] t;
		rem  = '0;
		root = '0;
		for (int k = 0; k <= Q48; k++) begin
			rem = (rem << 2) | ((k == 0) ? 64'd3 : 64'd0);
			t   = (root << 2) | 64'd1;
			if (rem >= t) begin
				rem  = rem - t;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	localparam logic [63:0] SQRT3_Q48 = sqrt3_q48();

	// One edge of the chain as exact (a, b) pairs for x and y
	function automatic pfx_vec_t side_vec(input logic [IDX_BITS-1:0] src, input logic refl,
	                                      input logic [DIR_BITS-1:0] turn);
		logic [3:0]        e1;
		logic [4:0]        ksum;
		logic [3:0]        k;
		logic [3:0]        ks;
		pfx_vec_t          v;
		e1   = refl ? E1_REF[src] : E1_FWD[src];
		ksum = {1'b0, e1} + {1'b0, turn};
		k    = (ksum >= 5'(TURN_STEPS)) ? 4'(ksum - 5'(TURN_STEPS)) : ksum[3:0];
		ks   = (k >= 4'd3) ? k - 4'd3 : k + 4'd9;
		if (EDGE_LONG[src]) begin
			v.ax = pfx_t'(3 * COS_RT3[k]);
			v.bx = pfx_t'(COS_INT[k]);
			v.ay = pfx_t'(3 * COS_RT3[ks]);
			v.by = pfx_t'(COS_INT[ks]);
		end else begin
			v.ax = pfx_t'(COS_INT[k]);
			v.bx = pfx_t'(COS_RT3[k]);
			v.ay = pfx_t'(COS_INT[ks]);
			v.by = pfx_t'(COS_RT3[ks]);
		end
		return v;
	endfunction

	function automatic pfx_vec_t pfx_add(input pfx_vec_t a, input pfx_vec_t b);
		pfx_vec_t r;
		r.ax = a.ax + b.ax;
		r.bx = a.bx + b.bx;
		r.ay = a.ay + b.ay;
		r.by = a.by + b.by;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/htvp_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface htvp_in_if #(parameter int COORD_BITS = 32) ();
	import htvp_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic [DIR_BITS-1:0]          direction;
	logic                         reflected;
	logic [IDX_BITS-1:0]          pivot;

	modport source (output valid, pos_x, pos_y, direction, reflected, pivot, input ready);
	modport sink   (input valid, pos_x, pos_y, direction, reflected, pivot, output ready);
endinterface

`default_nettype wire

// ----- hdl/htvp_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface htvp_out_if #(parameter int COORD_BITS = 32) ();
	import htvp_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [IDX_BITS-1:0]          vertex_index;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic                         tile_reflected;
	logic                         last_vertex;
	logic signed [COORD_BITS-1:0] box_min_x;
	logic signed [COORD_BITS-1:0] box_max_x;
	logic signed [COORD_BITS-1:0] box_min_y;
	logic signed [COORD_BITS-1:0] box_max_y;

	modport source (output valid, vertex_index, vertex_x, vertex_y, tile_reflected,
	                last_vertex, box_min_x, box_max_x, box_min_y, box_max_y,
	                input ready);
	modport sink   (input valid, vertex_index, vertex_x, vertex_y, tile_reflected,
	                last_vertex, box_min_x, box_max_x, box_min_y, box_max_y,
	                output ready);
endinterface

`default_nettype wire

// ----- hdl/hat_tile_vertex_placer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel | Role  | Beat
// tile    | sink  | one hat tile: pos_x, pos_y, direction, reflected, pivot
// vtx     | source| one vertex: index, x, y, reflected, last flag, running box
//
// A tile yields 14 vertex beats, one per cycle while vtx is ready; the emitter,
// walking the shifted chain one vertex a cycle, sets the sustained tile rate.
// The chain builder adds one edge per cycle and holds its last edge until the
// queue has room; the built chain then passes the queue and the emitter pipe.
// Reset (arst_n low) empties the queue and sets the box to its empty extremes.
// A stall on vtx holds the emitter pipe; the two-tile queue lets tile keep going.

module hat_tile_vertex_placer_unit #(
	parameter int COORD_BITS    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	htvp_in_if.sink    tile,
	htvp_out_if.source vtx
);
	import htvp_pkg::*;

	localparam int GEOM_W = $bits(tile_geom_t);
	localparam int REC_W  = GEOM_W + 2 * COORD_BITS;

	logic                         push_valid;
	logic                         push_ready;
	tile_geom_t                   push_geom;
	logic signed [COORD_BITS-1:0] push_px;
	logic signed [COORD_BITS-1:0] push_py;
	logic                         pop_valid;
	logic                         pop_ready;
	tile_geom_t                   pop_geom;
	logic signed [COORD_BITS-1:0] pop_px;
	logic signed [COORD_BITS-1:0] pop_py;
	logic [REC_W-1:0]             push_data;
	logic [REC_W-1:0]             pop_data;

	assign push_data = {push_geom, push_px, push_py};
	assign pop_geom  = pop_data[REC_W-1 -: GEOM_W];
	assign pop_px    = pop_data[2*COORD_BITS-1 -: COORD_BITS];
	assign pop_py    = pop_data[COORD_BITS-1:0];

	// chain builder
	htvp_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tile       (tile),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_geom  (push_geom),
		.push_px    (push_px),
		.push_py    (push_py)
	);

	// tile queue between builder and emitter
	htvp_queue #(
		.WIDTH (REC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// vertex emitter
	htvp_back #(
		.COORD_BITS    (COORD_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_geom  (pop_geom),
		.pop_px    (pop_px),
		.pop_py    (pop_py),
		.vtx       (vtx)
	);

endmodule

`default_nettype wire

// ----- hdl/htvp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module htvp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = slot_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/htvp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "hat_tile_vertex_placer_unit_defines.svh"

module htvp_front #(
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	htvp_in_if.sink                      tile,
	output logic                         push_valid,
	input  logic                         push_ready,
	output htvp_pkg::tile_geom_t         push_geom,
	output logic signed [COORD_BITS-1:0] push_px,
	output logic signed [COORD_BITS-1:0] push_py
);
	import htvp_pkg::*;

	logic                         busy_q;
	logic [IDX_BITS-1:0]          j_q;
	logic signed [COORD_BITS-1:0] px_q;
	logic signed [COORD_BITS-1:0] py_q;
	logic                         refl_q;
	logic [IDX_BITS-1:0]          piv_q;
	logic [DIR_BITS-1:0]          turn_q;
	pfx_vec_t                     acc_q;
	pfx_vec_t                     pts_q [TILE_VERTS-2:1];

	logic                         accept;
	logic                         last_step;
	logic                         step_en;
	logic [DIR_BITS-1:0]          dir_m;
	logic [DIR_BITS-1:0]          turn_in;
	logic [IDX_BITS-1:0]          piv_in;
	logic [IDX_BITS-1:0]          jj;
	logic [IDX_BITS:0]            src_sum;
	logic [IDX_BITS-1:0]          src;
	pfx_vec_t                     acc_nxt;

	// the chain is done once vertex 13 is known; it leaves with the push
	assign last_step  = busy_q && (j_q == IDX_BITS'(TILE_VERTS - 2));
	assign step_en    = busy_q && (!last_step || push_ready);
	assign tile.ready = !busy_q || (last_step && push_ready);
	assign accept     = tile.valid && tile.ready;

	// fold direction and pivot into range, mirror the turn
	always_comb begin
		dir_m   = (tile.direction >= DIR_BITS'(TURN_STEPS)) ?
		          tile.direction - DIR_BITS'(TURN_STEPS) : tile.direction;
		turn_in = (tile.reflected && (dir_m != '0)) ? DIR_BITS'(TURN_STEPS) - dir_m : dir_m;
		piv_in  = (tile.pivot >= IDX_BITS'(TILE_VERTS)) ?
		          tile.pivot - IDX_BITS'(TILE_VERTS) : tile.pivot;
	end

	// edge of the chain for this step, walked backwards when mirrored
	always_comb begin
		jj      = refl_q ? IDX_BITS'(TILE_VERTS - 1) - j_q : j_q;
		src_sum = {1'b0, piv_q} + {1'b0, jj};
		src     = (src_sum >= (IDX_BITS + 1)'(TILE_VERTS)) ?
		          IDX_BITS'(src_sum - (IDX_BITS + 1)'(TILE_VERTS)) : src_sum[IDX_BITS-1:0];
		acc_nxt = pfx_add(acc_q, side_vec(src, refl_q, turn_q));
	end

	// hand-off record
	always_comb begin
		push_valid     = last_step;
		push_px        = px_q;
		push_py        = py_q;
		push_geom.refl = refl_q;
		push_geom.piv  = piv_q;
		for (int v = 0; v < TILE_VERTS; v++) begin
			if (v == 0) begin
				push_geom.pts[v] = '0;
			end else if (v == TILE_VERTS - 1) begin
				push_geom.pts[v] = acc_nxt;
			end else begin
				push_geom.pts[v] = pts_q[v];
			end
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			j_q    <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			j_q    <= '0;
		end else if (step_en) begin
			j_q <= j_q + 1'b1;
			if (last_step) begin
				busy_q <= 1'b0;
			end
		end
	end

	// tile fields and running chain sum
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q   <= tile.pos_x;
			py_q   <= tile.pos_y;
			refl_q <= tile.reflected;
			piv_q  <= piv_in;
			turn_q <= turn_in;
			acc_q  <= '0;
		end else if (step_en && !last_step) begin
			acc_q                <= acc_nxt;
			pts_q[j_q + 1'b1]    <= acc_nxt;
		end
	end

	`HTVP_ASSERT_NOW(a_front_fields_folded, clk, arst_n, busy_q,
		(piv_q < IDX_BITS'(TILE_VERTS)) && (turn_q < DIR_BITS'(TURN_STEPS)),
		"front: pivot or turn out of range")
	`HTVP_ASSERT_NOW(a_front_step_bound, clk, arst_n, busy_q,
		j_q <= IDX_BITS'(TILE_VERTS - 2), "front: step counter overran the chain")
	`HTVP_ASSERT_NEXT(a_front_push_frees, clk, arst_n, push_valid && push_ready && !accept,
		!busy_q, "front: still busy after handing off a tile")

endmodule

`default_nettype wire

// ----- hdl/htvp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "hat_tile_vertex_placer_unit_defines.svh"

module htvp_back #(
	parameter int COORD_BITS    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pop_valid,
	output logic                         pop_ready,
	input  htvp_pkg::tile_geom_t         pop_geom,
	input  logic signed [COORD_BITS-1:0] pop_px,
	input  logic signed [COORD_BITS-1:0] pop_py,
	htvp_out_if.source                   vtx
);
	import htvp_pkg::*;

	localparam int NW = 60;
	localparam int SH = 49 - FRACTION_BITS;
	localparam int RW = NW - SH;
	localparam int SW = ((COORD_BITS > RW) ? COORD_BITS : RW) + 1;

	localparam logic signed [NW-1:0]         S3C    = $signed(NW'(SQRT3_Q48));
	localparam logic signed [NW-1:0]         ROUND  = $signed(NW'(64'd1 << (SH - 1)));
	localparam logic signed [SW-1:0]         SAT_HI = SW'({1'b0, {(COORD_BITS - 1){1'b1}}});
	localparam logic signed [SW-1:0]         SAT_LO = ~SAT_HI;
	localparam logic signed [COORD_BITS-1:0] C_MAX  = {1'b0, {(COORD_BITS - 1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] C_MIN  = ~C_MAX;

	logic                         ce;
	logic                         issue;
	logic [IDX_BITS-1:0]          i_q;
	logic [IDX_BITS-1:0]          s_idx;
	pfx_vec_t                     pt;

	logic                         v_s1, v_s2, v_s3, v_s4;
	logic [IDX_BITS-1:0]          idx_s1, idx_s2, idx_s3, idx_s4;
	logic                         last_s1, last_s2, last_s3, last_s4;
	logic                         refl_s1, refl_s2, refl_s3, refl_s4;
	logic signed [COORD_BITS-1:0] px_s1, px_s2, px_s3;
	logic signed [COORD_BITS-1:0] py_s1, py_s2, py_s3;
	pfx_vec_t                     pt_s1;
	pfx_t                         ax_s2, ay_s2;
	logic signed [NW-1:0]         prodx_s2, prody_s2;
	logic signed [RW-1:0]         rx_s3, ry_s3;
	logic signed [COORD_BITS-1:0] vx_s4, vy_s4;

	logic signed [NW-1:0]         nx, ny;
	logic signed [NW-1:0]         shx, shy;
	logic signed [SW-1:0]         sumx, sumy;
	logic signed [COORD_BITS-1:0] vx, vy;

	// whole pipe holds while the output beat waits
	assign ce        = !vtx.valid || vtx.ready;
	assign issue     = pop_valid && ce;
	assign pop_ready = ce && (i_q == IDX_LAST);

	// chain slot of vertex i after the cyclic shift by the pivot
	always_comb begin
		s_idx = (i_q >= pop_geom.piv) ? i_q - pop_geom.piv :
		        i_q + IDX_BITS'(TILE_VERTS) - pop_geom.piv;
		pt    = pop_geom.pts[s_idx];
	end

	// exact-to-fixed rounding, half up
	always_comb begin
		nx  = (NW'(ax_s2) <<< Q48) + prodx_s2 + ROUND;
		ny  = (NW'(ay_s2) <<< Q48) + prody_s2 + ROUND;
		shx = nx >>> SH;
		shy = ny >>> SH;
	end

	// translate and saturate
	always_comb begin
		sumx = SW'(px_s3) + SW'(rx_s3);
		sumy = SW'(py_s3) + SW'(ry_s3);
		if (sumx > SAT_HI) begin
			vx = SAT_HI[COORD_BITS-1:0];
		end else if (sumx < SAT_LO) begin
			vx = SAT_LO[COORD_BITS-1:0];
		end else begin
			vx = sumx[COORD_BITS-1:0];
		end
		if (sumy > SAT_HI) begin
			vy = SAT_HI[COORD_BITS-1:0];
		end else if (sumy < SAT_LO) begin
			vy = SAT_LO[COORD_BITS-1:0];
		end else begin
			vy = sumy[COORD_BITS-1:0];
		end
	end

	// vertex counter, stage valids, output valid and the running box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q           <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
			vtx.valid     <= 1'b0;
			vtx.box_min_x <= C_MAX;
			vtx.box_max_x <= C_MIN;
			vtx.box_min_y <= C_MAX;
			vtx.box_max_y <= C_MIN;
		end else if (ce) begin
			if (issue) begin
				i_q <= (i_q == IDX_LAST) ? '0 : i_q + 1'b1;
			end
			v_s1      <= issue;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			vtx.valid <= v_s4;
			if (v_s4) begin
				if (vx_s4 < vtx.box_min_x) vtx.box_min_x <= vx_s4;
				if (vx_s4 > vtx.box_max_x) vtx.box_max_x <= vx_s4;
				if (vy_s4 < vtx.box_min_y) vtx.box_min_y <= vy_s4;
				if (vy_s4 > vtx.box_max_y) vtx.box_max_y <= vy_s4;
			end
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (ce) begin
			// s1: slot read
			idx_s1  <= i_q;
			last_s1 <= (i_q == IDX_LAST);
			refl_s1 <= pop_geom.refl;
			px_s1   <= pop_px;
			py_s1   <= pop_py;
			pt_s1   <= pt;
			// s2: sqrt3 products
			idx_s2   <= idx_s1;
			last_s2  <= last_s1;
			refl_s2  <= refl_s1;
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			ax_s2    <= pt_s1.ax;
			ay_s2    <= pt_s1.ay;
			prodx_s2 <= NW'(pt_s1.bx) * S3C;
			prody_s2 <= NW'(pt_s1.by) * S3C;
			// s3: rounded offset
			idx_s3  <= idx_s2;
			last_s3 <= last_s2;
			refl_s3 <= refl_s2;
			px_s3   <= px_s2;
			py_s3   <= py_s2;
			rx_s3   <= shx[RW-1:0];
			ry_s3   <= shy[RW-1:0];
			// s4: world vertex
			idx_s4  <= idx_s3;
			last_s4 <= last_s3;
			refl_s4 <= refl_s3;
			vx_s4   <= vx;
			vy_s4   <= vy;
			// output beat
			if (v_s4) begin
				vtx.vertex_index   <= idx_s4;
				vtx.vertex_x       <= vx_s4;
				vtx.vertex_y       <= vy_s4;
				vtx.tile_reflected <= refl_s4;
				vtx.last_vertex    <= last_s4;
			end
		end
	end

	`HTVP_ASSERT_NOW(a_back_box_holds_vertex, clk, arst_n, vtx.valid,
		(vtx.box_min_x <= vtx.vertex_x) && (vtx.vertex_x <= vtx.box_max_x) &&
		(vtx.box_min_y <= vtx.vertex_y) && (vtx.vertex_y <= vtx.box_max_y),
		"back: vertex lies outside the running box")
	`HTVP_ASSERT_NOW(a_back_last_flag, clk, arst_n, vtx.valid,
		vtx.last_vertex == (vtx.vertex_index == IDX_LAST),
		"back: last flag does not match vertex index")
	`HTVP_ASSERT_NEXT(a_back_stall_holds, clk, arst_n, vtx.valid && !vtx.ready,
		$stable(vtx.box_min_x) && $stable(vtx.box_max_y) && $stable(i_q),
		"back: state moved during an output stall")

endmodule

`default_nettype wire
